@@ rtl/core/eai_pkg.sv @@
// Shared types, constants and codes for the excitation amplitude indexer.
// No dependencies; every other file of the block depends on this package.
package eai_pkg;

  localparam int MaxOrbitals   = 32;
  localparam int OrbW          = $clog2(MaxOrbitals);
  localparam int SpinW         = $clog2(2 * MaxOrbitals);
  localparam int CntW          = 6;
  localparam int OccW          = 64;
  localparam int AmpW          = 64;
  localparam int IdxW          = 10;
  localparam int TgtW          = 3;
  localparam int CfgIdxW       = 1;
  localparam int OrbCountReset = 32;
  localparam int OccCountReset = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOrbCount = 1'b0,
    CfgOccCount = 1'b1
  } cfg_reg_e;

  typedef enum logic [TgtW-1:0] {
    TgtNone       = 3'd0,
    TgtAlpha      = 3'd1,
    TgtBeta       = 3'd2,
    TgtAlphaAlpha = 3'd3,
    TgtBetaBeta   = 3'd4,
    TgtAlphaBeta  = 3'd5
  } target_e;

  // First and second spin-orbital picked by a hole or particle scan
  typedef struct packed {
    logic             v1;
    logic             v2;
    logic [SpinW-1:0] s1;
    logic [SpinW-1:0] s2;
  } pick_t;

  typedef struct packed {
    logic [OccW-1:0] occ;
    logic [AmpW-1:0] amp;
    pick_t           hole;
    pick_t           part;
  } stage_t;

  typedef struct packed {
    target_e         target;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] column;
    logic [AmpW-1:0] value;
  } res_t;

endpackage

@@ rtl/core/eai_in_if.sv @@
// Input channel: one determinant (occupation word and amplitude) per beat.
// Depends on eai_pkg for field widths.
interface eai_in_if;
  logic                      valid;
  logic                      ready;
  logic [eai_pkg::OccW-1:0]  occupation;
  logic [eai_pkg::AmpW-1:0]  amplitude;

  modport source (output valid, output occupation, output amplitude, input ready);
  modport sink   (input valid, input occupation, input amplitude, output ready);
endinterface

@@ rtl/core/eai_out_if.sv @@
// Output channel: matrix code, row, column and amplitude per beat.
// Depends on eai_pkg for field widths.
interface eai_out_if;
  logic                      valid;
  logic                      ready;
  logic [eai_pkg::TgtW-1:0]  target;
  logic [eai_pkg::IdxW-1:0]  row;
  logic [eai_pkg::IdxW-1:0]  column;
  logic [eai_pkg::AmpW-1:0]  value;

  modport source (output valid, output target, output row, output column, output value,
                  input ready);
  modport sink   (input valid, input target, input row, input column, input value,
                  output ready);
endinterface

@@ rtl/core/eai_cell.sv @@
// One orbital cell of the scan chain: updates the hole or particle pick
// for its orbital and registers the beat. Depends on eai_pkg.
module eai_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [eai_pkg::OrbW-1:0]  orb_i,
  input  logic [eai_pkg::CntW-1:0]  norb_i,
  input  logic [eai_pkg::CntW-1:0]  nocc_i,
  input  logic                      valid_i,
  input  eai_pkg::stage_t           stage_i,
  output logic                      valid_o,
  output eai_pkg::stage_t           stage_o
);
  import eai_pkg::*;

  function automatic pick_t pick_update(pick_t p, logic a, logic b, logic want,
                                        logic [SpinW-1:0] r);
    pick_t n;
    n = p;
    if (a == want && b == want) begin
      // both spins hit: override any earlier picks
      n.v1 = 1'b1;
      n.s1 = r;
      n.v2 = 1'b1;
      n.s2 = {r[SpinW-1:1], 1'b1};
    end else if (a == want) begin
      if (p.v1) begin
        n.v2 = 1'b1;
        n.s2 = r;
      end else begin
        n.v1 = 1'b1;
        n.s1 = r;
      end
    end else if (b == want) begin
      if (p.v1) begin
        n.v2 = 1'b1;
        n.s2 = {r[SpinW-1:1], 1'b1};
      end else begin
        n.v1 = 1'b1;
        n.s1 = {r[SpinW-1:1], 1'b1};
      end
    end
    return n;
  endfunction

  logic            alpha;
  logic            beta;
  logic            in_hole;
  logic            in_part;
  logic [CntW-1:0] rel;
  stage_t          stage_d;
  stage_t          stage_q;
  logic            valid_q;

  always_comb begin
    alpha   = stage_i.occ[{orb_i, 1'b0}];
    beta    = stage_i.occ[{orb_i, 1'b1}];
    in_hole = CntW'(orb_i) < nocc_i;
    in_part = !in_hole && (CntW'(orb_i) < norb_i);
    rel     = CntW'(orb_i) - nocc_i;
    stage_d = stage_i;
    if (in_hole) begin
      stage_d.hole = pick_update(stage_i.hole, alpha, beta, 1'b0, {orb_i, 1'b0});
    end else if (in_part) begin
      stage_d.part = pick_update(stage_i.part, alpha, beta, 1'b1, {rel[OrbW-1:0], 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

@@ rtl/core/eai_index.sv @@
// Classification and index stage: turns the final hole and particle picks
// into matrix code, row and column. Depends on eai_pkg.
module eai_index (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [eai_pkg::CntW-1:0]  nocc_i,
  input  logic [eai_pkg::CntW-1:0]  nvirt_i,
  input  logic                      valid_i,
  input  eai_pkg::stage_t           stage_i,
  output logic                      valid_o,
  output eai_pkg::res_t             res_o
);
  import eai_pkg::*;

  localparam int ProdW = OrbW + CntW;

  // triangular pair packing over spatial orbitals
  function automatic logic [IdxW-1:0] tri_pack(logic [SpinW-1:0] x, logic [SpinW-1:0] y);
    logic [OrbW-1:0]  hi;
    logic [OrbW-1:0]  lo;
    logic [ProdW-1:0] prod;
    hi   = (x > y) ? x[SpinW-1:1] : y[SpinW-1:1];
    lo   = (x > y) ? y[SpinW-1:1] : x[SpinW-1:1];
    prod = ProdW'(hi) * ProdW'({1'b0, hi} + 1'b1);
    return IdxW'((prod >> 1) + ProdW'(lo));
  endfunction

  pick_t           h;
  pick_t           p;
  logic            e1;
  logic            e2;
  logic            pe;
  logic [OrbW-1:0] hi_i;
  logic [OrbW-1:0] hi_j;
  logic [OrbW-1:0] pa;
  logic [OrbW-1:0] pb;
  logic [ProdW-1:0] row_ab;
  logic [ProdW-1:0] col_ab;
  res_t            res_d;
  res_t            res_q;
  logic            valid_q;

  always_comb begin
    h      = stage_i.hole;
    p      = stage_i.part;
    e1     = !h.s1[0];
    e2     = !h.s2[0];
    pe     = !p.s1[0];
    hi_i   = e1 ? h.s1[SpinW-1:1] : h.s2[SpinW-1:1];
    hi_j   = e1 ? h.s2[SpinW-1:1] : h.s1[SpinW-1:1];
    pa     = pe ? p.s1[SpinW-1:1] : p.s2[SpinW-1:1];
    pb     = pe ? p.s2[SpinW-1:1] : p.s1[SpinW-1:1];
    row_ab = ProdW'(hi_i) * ProdW'(nocc_i) + ProdW'(hi_j);
    col_ab = ProdW'(pa) * ProdW'(nvirt_i) + ProdW'(pb);

    res_d.target = TgtNone;
    res_d.row    = '0;
    res_d.column = '0;
    res_d.value  = '0;
    if (h.v1 && !h.v2) begin
      res_d.target = h.s1[0] ? TgtBeta : TgtAlpha;
      res_d.row    = IdxW'(h.s1[SpinW-1:1]);
      // a single without particle lands in column zero
      res_d.column = p.v1 ? IdxW'(p.s1[SpinW-1:1]) : '0;
      res_d.value  = stage_i.amp;
    end else if (h.v1 && h.v2 && p.v1 && p.v2) begin
      res_d.value = stage_i.amp;
      if (e1 == e2) begin
        res_d.target = e1 ? TgtAlphaAlpha : TgtBetaBeta;
        res_d.row    = tri_pack(h.s1, h.s2);
        res_d.column = tri_pack(p.s1, p.s2);
      end else begin
        res_d.target = TgtAlphaBeta;
        res_d.row    = row_ab[IdxW-1:0];
        res_d.column = col_ab[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

@@ rtl/core/eai_skid.sv @@
// Output register plus skid register: keeps the upstream ready registered
// so the chain keeps moving while one result waits. Depends on eai_pkg.
module eai_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  eai_pkg::res_t  res_i,
  output logic           ready_o,
  output logic           valid_o,
  output eai_pkg::res_t  res_o,
  input  logic           ready_i
);
  import eai_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  logic take;
  logic out_free;
  res_t out_q;
  res_t skid_q;

  assign take     = valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_free) begin
      // hold the stalled beat, park a new one in the skid slot
      if (take) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_free) begin
      if (take) begin
        skid_q <= res_i;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (take) begin
      out_q <= res_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;
endmodule

@@ rtl/core/excitation_amplitude_indexer.sv @@
// Excitation amplitude indexer, top level: config registers, 32-cell orbital chain,
// index stage and output skid. Depends on eai_pkg, eai_in_if, eai_out_if, eai_cell,
// eai_index, eai_skid.
// Pipeline: 32 orbital cells, index stage and output register from input beat to output
// valid. Throughput: one determinant per cycle while the output skid slot is empty.
// Reset clears all valid bits and loads orbital_count 32, occupied_count 16.
module excitation_amplitude_indexer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  eai_in_if.sink                       in_i,
  eai_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [eai_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [eai_pkg::CntW-1:0]     cfg_data_i
);
  import eai_pkg::*;

  logic [CntW-1:0] norb_q;
  logic [CntW-1:0] nocc_q;
  logic [CntW-1:0] norb_eff;
  logic [CntW-1:0] nocc_eff;
  logic [CntW-1:0] nvirt;
  logic            en;
  logic            idx_valid;
  res_t            idx_res;
  res_t            out_res;
  logic            chain_valid [MaxOrbitals+1];
  stage_t          chain_stage [MaxOrbitals+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norb_q <= CntW'(OrbCountReset);
      nocc_q <= CntW'(OccCountReset);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgOrbCount: norb_q <= cfg_data_i;
        CfgOccCount: nocc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturate the counts
  always_comb begin
    norb_eff = (norb_q > CntW'(MaxOrbitals)) ? CntW'(MaxOrbitals) : norb_q;
    nocc_eff = (nocc_q > norb_eff) ? norb_eff : nocc_q;
    nvirt    = norb_eff - nocc_eff;
  end

  always_comb begin
    chain_valid[0]      = in_i.valid && en;
    chain_stage[0].occ  = in_i.occupation;
    chain_stage[0].amp  = in_i.amplitude;
    chain_stage[0].hole = '0;
    chain_stage[0].part = '0;
  end

  for (genvar g = 0; g < MaxOrbitals; g++) begin : g_cell
    eai_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .orb_i   (OrbW'(g)),
      .norb_i  (norb_eff),
      .nocc_i  (nocc_eff),
      .valid_i (chain_valid[g]),
      .stage_i (chain_stage[g]),
      .valid_o (chain_valid[g+1]),
      .stage_o (chain_stage[g+1])
    );
  end

  eai_index u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .nocc_i  (nocc_eff),
    .nvirt_i (nvirt),
    .valid_i (chain_valid[MaxOrbitals]),
    .stage_i (chain_stage[MaxOrbitals]),
    .valid_o (idx_valid),
    .res_o   (idx_res)
  );

  eai_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (idx_valid),
    .res_i   (idx_res),
    .ready_o (en),
    .valid_o (out_o.valid),
    .res_o   (out_res),
    .ready_i (out_o.ready)
  );

  assign in_i.ready   = en;
  assign out_o.target = out_res.target;
  assign out_o.row    = out_res.row;
  assign out_o.column = out_res.column;
  assign out_o.value  = out_res.value;
endmodule

@@ rtl/core/eai_checker.sv @@
// Port-level checks for the excitation amplitude indexer, bound to the top level.
// Depends on eai_pkg.
module eai_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [eai_pkg::TgtW-1:0]  target_i,
  input logic [eai_pkg::IdxW-1:0]  row_i,
  input logic [eai_pkg::IdxW-1:0]  column_i,
  input logic [eai_pkg::AmpW-1:0]  value_i
);
  import eai_pkg::*;

  // a stalled output beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // input backpressure only follows a stalled output beat
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input ready low without output stall");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && target_i == TgtNone |-> row_i == '0 && column_i == '0 && value_i == '0)
    else $error("no-excitation beat carries nonzero fields");

  a_single_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (target_i == TgtAlpha || target_i == TgtBeta)
      |-> row_i < IdxW'(MaxOrbitals) && column_i < IdxW'(MaxOrbitals))
    else $error("single index out of orbital range");
endmodule

bind excitation_amplitude_indexer eai_checker u_eai_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .target_i    (out_o.target),
  .row_i       (out_o.row),
  .column_i    (out_o.column),
  .value_i     (out_o.value)
);

@@ tb/excitation_amplitude_indexer_tb.sv @@
// Self-checking testbench for excitation_amplitude_indexer: random and directed determinants
// under several orbital settings, with a built-in predictor of the matrix entry per beat.
// Depends on eai_pkg, eai_in_if, eai_out_if and the block's RTL.
module excitation_amplitude_indexer_tb;
  import eai_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxWait    = 17;
  localparam logic [OccW-1:0] RefWord = 64'h0000_0000_ffff_ffff;

  typedef struct {
    logic [OccW-1:0] occ;
    logic [AmpW-1:0] amp;
    bit              drain;
  } det_t;

  typedef struct {
    target_e         target;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] column;
    logic [AmpW-1:0] value;
  } mat_entry_t;

  typedef struct {
    bit v1;
    bit v2;
    int s1;
    int s2;
  } spin_pick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CntW-1:0]     cfg_data_i;

  eai_in_if  in_bus ();
  eai_out_if out_bus ();

  excitation_amplitude_indexer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  det_t       det_queue[$];
  mat_entry_t entry_queue[$];
  logic [CntW-1:0] orb_setting = CntW'(OrbCountReset);
  logic [CntW-1:0] occ_setting = CntW'(OccCountReset);
  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  bit send_burst  = 1'b0;
  bit recv_burst  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  // Holes look for empty spin-orbitals, particles for filled ones; a fully matching
  // orbital overrides whatever was picked before it.
  function automatic spin_pick_t scan_orbitals(logic [OccW-1:0] occ, int lo, int hi, bit want);
    spin_pick_t p;
    bit a, b;
    int r;
    p = '{default: 0};
    for (int j = lo; j < hi; j++) begin
      a = occ[2*j];
      b = occ[2*j+1];
      r = 2 * (j - lo);
      if (a == want && b == want) begin
        p.v1 = 1'b1; p.s1 = r;
        p.v2 = 1'b1; p.s2 = r + 1;
      end else if (a == want) begin
        if (p.v1) begin
          p.v2 = 1'b1; p.s2 = r;
        end else begin
          p.v1 = 1'b1; p.s1 = r;
        end
      end else if (b == want) begin
        if (p.v1) begin
          p.v2 = 1'b1; p.s2 = r + 1;
        end else begin
          p.v1 = 1'b1; p.s1 = r + 1;
        end
      end
    end
    return p;
  endfunction

  function automatic int tri_pack(int x, int y);
    int hi, lo;
    hi = (x > y ? x : y) / 2;
    lo = (x > y ? y : x) / 2;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  function automatic void eff_counts(output int norb, output int nocc);
    norb = orb_setting;
    if (norb > MaxOrbitals) norb = MaxOrbitals;
    nocc = occ_setting;
    if (nocc > norb) nocc = norb;
  endfunction

  function automatic mat_entry_t locate_amplitude(logic [OccW-1:0] occ, logic [AmpW-1:0] amp);
    mat_entry_t e;
    spin_pick_t h, p;
    int norb, nocc, nvirt, row, col, i, j, a, b;
    bit e1, e2, pe;
    eff_counts(norb, nocc);
    nvirt = norb - nocc;
    h = scan_orbitals(occ, 0, nocc, 1'b0);
    p = scan_orbitals(occ, nocc, norb, 1'b1);
    e.target = TgtNone;
    e.value  = '0;
    row = 0;
    col = 0;
    if (h.v1 && !h.v2) begin
      e.target = (h.s1 % 2) ? TgtBeta : TgtAlpha;
      row = h.s1 / 2;
      col = p.v1 ? p.s1 / 2 : 0;
      e.value = amp;
    end else if (h.v1 && h.v2 && p.v1 && p.v2) begin
      e1 = (h.s1 % 2) == 0;
      e2 = (h.s2 % 2) == 0;
      if (e1 == e2) begin
        // same-spin holes fix the packing, whatever the particle spins
        e.target = e1 ? TgtAlphaAlpha : TgtBetaBeta;
        row = tri_pack(h.s1, h.s2);
        col = tri_pack(p.s1, p.s2);
      end else begin
        i  = e1 ? h.s1 / 2 : h.s2 / 2;
        j  = e1 ? h.s2 / 2 : h.s1 / 2;
        pe = (p.s1 % 2) == 0;
        a  = pe ? p.s1 / 2 : p.s2 / 2;
        b  = pe ? p.s2 / 2 : p.s1 / 2;
        e.target = TgtAlphaBeta;
        row = i * nocc + j;
        col = a * nvirt + b;
      end
      e.value = amp;
    end
    e.row    = row[IdxW-1:0];
    e.column = col[IdxW-1:0];
    return e;
  endfunction

  // Start from the reference determinant, pull electrons out of the occupied block and
  // drop them into the virtual block; optionally scramble the unused upper bits.
  function automatic logic [OccW-1:0] excited_det(int norb, int nocc, int nholes, int nparts);
    logic [OccW-1:0] w;
    w = '0;
    for (int j = 0; j < 2 * nocc; j++) w[j] = 1'b1;
    if (nocc > 0)
      for (int k = 0; k < nholes; k++) w[$urandom_range(2 * nocc - 1, 0)] = 1'b0;
    if (norb > nocc)
      for (int k = 0; k < nparts; k++) w[$urandom_range(2 * norb - 1, 2 * nocc)] = 1'b1;
    if ($urandom_range(1, 0))
      for (int j = 2 * norb; j < OccW; j++) w[j] = $urandom_range(1, 0);
    return w;
  endfunction

  function automatic logic [AmpW-1:0] random_amp();
    int pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic void add_det(logic [OccW-1:0] occ, logic [AmpW-1:0] amp, bit drain);
    det_t d;
    d.occ   = occ;
    d.amp   = amp;
    d.drain = drain;
    det_queue.push_back(d);
  endfunction

  function automatic void add_random_dets(int count, bit force_drain);
    int norb, nocc, kind, np;
    logic [OccW-1:0] w;
    eff_counts(norb, nocc);
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99, 0);
      if (kind < 8) begin
        w = {$urandom, $urandom};
      end else if (kind < 18) begin
        w = excited_det(norb, nocc, $urandom_range(6, 0), $urandom_range(6, 0));
      end else if (kind < 30) begin
        w = excited_det(norb, nocc, 0, 0);
      end else if (kind < 60) begin
        np = ($urandom_range(7, 0) == 0) ? 0 : 1;
        w = excited_det(norb, nocc, 1, np);
      end else begin
        w = excited_det(norb, nocc, 2, 2);
      end
      add_det(w, random_amp(), (force_drain && n == 40) || $urandom_range(199, 0) == 0);
    end
  endfunction

  task automatic program_counts(input logic [CntW-1:0] orbs, input logic [CntW-1:0] occs);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgOrbCount;
    cfg_data_i <= orbs;
    @(posedge clk_i);
    cfg_idx_i  <= CfgOccCount;
    cfg_data_i <= occs;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    orb_setting = orbs;
    occ_setting = occs;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (det_queue.size() > 0 || entry_queue.size() > 0 || in_bus.valid);
  endtask

  // Driver: present queued determinants, with random idle gaps between beats.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit load;
    bit free;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      load = 1'b0;
      free = !in_bus.valid || in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        entry_queue.push_back(locate_amplitude(in_bus.occupation, in_bus.amplitude));
        if ($urandom_range(39, 0) == 0) send_burst = !send_burst;
        gap_left = send_burst ? 0 : $urandom_range(MaxWait, 0);
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (det_queue.size() > 0 &&
                     (!det_queue[0].drain || entry_queue.size() == 0)) begin
          load = 1'b1;
        end
      end
      if (load) begin
        in_bus.valid      <= 1'b1;
        in_bus.occupation <= det_queue[0].occ;
        in_bus.amplitude  <= det_queue[0].amp;
        void'(det_queue.pop_front());
      end else if (free) begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    mat_entry_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (entry_queue.size() == 0) begin
          report($sformatf("unexpected beat target %0d row %0d col %0d",
                           out_bus.target, out_bus.row, out_bus.column));
        end else begin
          want = entry_queue.pop_front();
          if (out_bus.target !== want.target)
            report($sformatf("target %0d, want %0d", out_bus.target, want.target));
          if (out_bus.row !== want.row)
            report($sformatf("row %0d, want %0d", out_bus.row, want.row));
          if (out_bus.column !== want.column)
            report($sformatf("column %0d, want %0d", out_bus.column, want.column));
          if (out_bus.value !== want.value)
            report($sformatf("value %h, want %h", out_bus.value, want.value));
        end
        if ($urandom_range(39, 0) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(MaxWait, 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_orb[15]   = '{32, 1, 1, 32, 32, 63, 0, 40, 2, 5, 12, 32, 32, 17, 20};
    int phase_occ[15]   = '{16, 0, 1, 0, 32, 63, 0, 20, 1, 2, 7, 31, 1, 9, 45};
    int phase_items[15] = '{150, 20, 20, 60, 60, 30, 10, 120, 60, 100, 120, 100, 100, 120, 40};
    int orbs, occs;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.occupation = '0;
    in_bus.amplitude  = '0;
    out_bus.ready     = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgOrbCount;
    cfg_data_i        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 32 orbitals, 16 occupied
    add_det(RefWord, '0, 1'b0);
    add_det('0, '1, 1'b0);
    add_det('1, 64'h8000_0000_0000_0001, 1'b0);
    add_det(64'h0000_0001_ffff_fffe, random_amp(), 1'b0);  // alpha single
    add_det(64'h8000_0000_7fff_ffff, random_amp(), 1'b0);  // beta single, top orbitals
    add_det(64'h0000_0000_ffff_ffef, random_amp(), 1'b0);  // single, no particle
    add_det(64'h0000_0005_ffff_fffa, random_amp(), 1'b0);  // alpha-alpha
    add_det(64'h0000_000a_ffff_fff5, random_amp(), 1'b0);  // beta-beta
    add_det(64'h0000_0003_ffff_fffc, random_amp(), 1'b0);  // both spins of one orbital
    add_det(64'h0000_2100_ffff_ffdb, random_amp(), 1'b0);  // alpha-beta
    add_det(64'h0000_000a_ffff_fffa, random_amp(), 1'b0);  // alpha holes, beta particles
    add_det(64'h0000_0012_ffff_ffed, random_amp(), 1'b0);  // odd spins picked first
    add_det(64'h0000_0005_ffff_f3fa, random_amp(), 1'b0);  // empty orbital overrides
    add_det(64'h0000_0015_ffff_ffea, random_amp(), 1'b0);  // third hole overwrites second
    add_det(64'h0000_0305_ffff_fffa, random_amp(), 1'b0);  // full virtual overrides
    add_det(64'h0000_0001_ffff_fffa, random_amp(), 1'b0);  // double, one particle
    add_det(64'h8000_0004_ffff_fffe, random_amp(), 1'b0);  // single, two particles
    add_det(64'hc000_0000_3fff_ffff, '1, 1'b0);
    add_det({$urandom, $urandom}, '0, 1'b0);
    add_det(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
    add_det(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 19; ph++) begin
      if (ph < 15) begin
        program_counts(CntW'(phase_orb[ph]), CntW'(phase_occ[ph]));
        add_random_dets(phase_items[ph], ph == 0);
      end else begin
        orbs = $urandom_range(MaxOrbitals, 1);
        occs = $urandom_range(orbs, 0);
        program_counts(CntW'(orbs), CntW'(occs));
        add_random_dets(110, 1'b0);
      end
      wait_drained();
    end

    // let any stray beat surface before the verdict
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
